// ----- rtl/dad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive activity detector package
// Field widths, register indexes, reset values and the per-drive status type.
// ----------------------------------------------------------------------------
package dad_pkg;

   localparam int PORT_W      = 8;
   localparam int NOW_W       = 64;
   localparam int REPORT_W    = 2;
   localparam int MASK_W      = 4;
   localparam int COUNT_W     = 32;
   localparam int PIN_W       = 3;
   localparam int PIN_MAP_W   = 12;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;

   localparam logic [PIN_MAP_W-1:0]   PIN_MAP_RESET    = 12'd1672;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_MAP      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL = 1'd1;

   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] edge_count;
      logic [NOW_W-1:0]   last_time;
   } dad_lane_status_type;

endpackage

// ----- rtl/dad_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive activity detector channels
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface dad_req_if;
   import dad_pkg::*;
   logic                valid;
   logic                ready;
   logic [PORT_W-1:0]   port_bits;
   logic [NOW_W-1:0]    now_us;
   logic [REPORT_W-1:0] report_drive;

   modport source (output valid, port_bits, now_us, report_drive, input ready);
   modport sink   (input valid, port_bits, now_us, report_drive, output ready);
endinterface

interface dad_rsp_if;
   import dad_pkg::*;
   logic               valid;
   logic               ready;
   logic [MASK_W-1:0]  active_mask;
   logic               sel_active;
   logic [COUNT_W-1:0] sel_event_count;
   logic [NOW_W-1:0]   sel_last_active_us;

   modport source (output valid, active_mask, sel_active, sel_event_count,
                   sel_last_active_us, input ready);
   modport sink   (input valid, active_mask, sel_active, sel_event_count,
                   sel_last_active_us, output ready);
endinterface

// ----- rtl/dad_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive activity lane
// Per-drive sample window, idle run, edge count, last active time and flag.
// ----------------------------------------------------------------------------
module dad_lane #(
   parameter int WINDOW = 25,
   parameter int HOLD   = 50
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  logic                         act,
   input  logic [dad_pkg::NOW_W-1:0]    now_us,
   output dad_pkg::dad_lane_status_type status
);
   import dad_pkg::*;

   localparam int IDLE_W = $clog2(HOLD + 1);

   logic [WINDOW-1:0]  hist_ff, hist_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [NOW_W-1:0]   time_ff, time_in;
   logic               active_ff, active_in;

   always_comb begin
      hist_in  = (hist_ff << 1) | WINDOW'(act);
      idle_in  = idle_ff;
      count_in = count_ff;
      time_in  = time_ff;
      if (act) begin
         idle_in = '0;
         time_in = now_us;
         if (!hist_ff[0]) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end else if (idle_ff < IDLE_W'(HOLD)) begin
         idle_in = idle_ff + IDLE_W'(1);
      end
      if (hist_in != '0) begin
         active_in = 1'b1;
      end else if (idle_in >= IDLE_W'(HOLD)) begin
         active_in = 1'b0;
      end else begin
         active_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         idle_ff   <= '0;
         count_ff  <= '0;
         time_ff   <= '0;
         active_ff <= 1'b0;
      end else if (update) begin
         hist_ff   <= hist_in;
         idle_ff   <= idle_in;
         count_ff  <= count_in;
         time_ff   <= time_in;
         active_ff <= active_in;
      end
   end

   assign status.active     = active_in;
   assign status.edge_count = count_in;
   assign status.last_time  = time_in;

   a_idle_bound: assert property (@(posedge clock) disable iff (reset)
      idle_ff <= IDLE_W'(HOLD))
      else $error("idle run above hold");

   a_window_active: assert property (@(posedge clock) disable iff (reset)
      hist_ff != '0 |-> active_ff)
      else $error("active sample in window but drive idle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      update |-> (count_in == count_ff) || (count_in == count_ff + COUNT_W'(1)))
      else $error("edge count moved by more than one");

endmodule

// ----- rtl/drive_activity_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive activity detector
// Pulse stretcher with hysteresis over per-drive activity pins.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per poll: the sampled pin byte, a timestamp
//   and the drive to report. rsp_chan returns one item per request: the
//   active mask and the selected drive's flag, edge count and last active
//   time. csr_we writes pin_map (index 0) or active_level (index 1); write
//   only while no item is in flight.
//   An item goes from the input register to the result register and
//   rsp_chan.valid; one item per cycle is sustained unless rsp_chan stalls,
//   as the per-drive update is a single combinational pass between them.
//   Reset clears all drive state and restores the register defaults.
//   When the receiver stalls, the result register holds and one more item
//   waits in the input register; req_chan.ready then drops.
// ----------------------------------------------------------------------------
module drive_activity_detector_top #(
   parameter int DRIVES = 4,
   parameter int WINDOW = 25,
   parameter int HOLD   = 50
) (
   input  logic                               clock,
   input  logic                               reset,
   dad_req_if.sink                            req_chan,
   dad_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [dad_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dad_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dad_pkg::*;

   logic [PIN_MAP_W-1:0] pin_map_ff;
   logic                 level_ff;

   logic                in_valid_ff;
   logic [PORT_W-1:0]   port_ff;
   logic [NOW_W-1:0]    now_ff;
   logic [REPORT_W-1:0] report_ff;

   logic               out_valid_ff, out_valid_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               sel_active_ff, sel_active_in;
   logic [COUNT_W-1:0] sel_count_ff, sel_count_in;
   logic [NOW_W-1:0]   sel_time_ff, sel_time_in;

   logic                advance;
   logic [DRIVES-1:0]   act;
   dad_lane_status_type status [DRIVES];

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_map_ff <= PIN_MAP_RESET;
         level_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PIN_MAP: begin
               pin_map_ff <= csr_wdata[PIN_MAP_W-1:0];
            end
            CSR_ACTIVE_LEVEL: begin
               level_ff <= csr_wdata[0];
            end
            default: begin
               pin_map_ff <= pin_map_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         port_ff   <= req_chan.port_bits;
         now_ff    <= req_chan.now_us;
         report_ff <= req_chan.report_drive;
      end
   end

   for (genvar d = 0; d < DRIVES; d++) begin : g_drive
      logic [PIN_W-1:0] pin;
      if (PIN_W * d + PIN_W <= PIN_MAP_W) begin : g_mapped
         assign pin = pin_map_ff[PIN_W*d +: PIN_W];
      end else begin : g_unmapped
         assign pin = '0;
      end
      assign act[d] = (port_ff[pin] == level_ff);

      dad_lane #(
         .WINDOW (WINDOW),
         .HOLD   (HOLD)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .update (advance),
         .act    (act[d]),
         .now_us (now_ff),
         .status (status[d])
      );
   end

   always_comb begin
      mask_in       = '0;
      sel_active_in = 1'b0;
      sel_count_in  = '0;
      sel_time_in   = '0;
      for (int d = 0; d < MASK_W && d < DRIVES; d++) begin
         mask_in[d] = status[d].active;
      end
      for (int d = 0; d < DRIVES; d++) begin
         if (int'(report_ff) == d) begin
            sel_active_in = status[d].active;
            sel_count_in  = status[d].edge_count;
            sel_time_in   = status[d].last_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mask_ff       <= mask_in;
         sel_active_ff <= sel_active_in;
         sel_count_ff  <= sel_count_in;
         sel_time_ff   <= sel_time_in;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.active_mask        = mask_ff;
   assign rsp_chan.sel_active         = sel_active_ff;
   assign rsp_chan.sel_event_count    = sel_count_ff;
   assign rsp_chan.sel_last_active_us = sel_time_ff;

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("processed item not presented");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("pending item lost");

   a_sel_in_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.sel_active |-> rsp_chan.active_mask != '0)
      else $error("selected drive active but mask empty");

endmodule
